// ===== sv/bsmd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsmd_pkg
// Shared types and constants for the bank-switched memory decoder: the item
// structs of both channels, the target store codes, the soft-switch flag bit
// positions, the address map and the configuration register indexes.
// ----------------------------------------------------------------------------
package bsmd_pkg;

  // Store that serves a bus access.
  typedef enum logic [4:0] {
    TGT_ZP       = 5'd0,
    TGT_AUXZP    = 5'd1,
    TGT_RAM      = 5'd2,
    TGT_AUXRAM   = 5'd3,
    TGT_SWITCH   = 5'd4,
    TGT_SPEAKER  = 5'd5,
    TGT_INTROM   = 5'd6,
    TGT_MOUSE    = 5'd7,
    TGT_DISK     = 5'd8,
    TGT_HD       = 5'd9,
    TGT_LC       = 5'd10,
    TGT_MAIN_B1  = 5'd11,
    TGT_AUX_B1   = 5'd12,
    TGT_MAIN_B21 = 5'd13,
    TGT_AUX_B21  = 5'd14,
    TGT_MAIN_B22 = 5'd15,
    TGT_AUX_B22  = 5'd16,
    TGT_SYSROM   = 5'd17,
    TGT_NONE     = 5'd18
  } target_t;

  // One bus access.
  typedef struct packed {
    logic        opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
    logic [11:0] switch_flags;
  } bsmd_in_t;

  // One routing result.
  typedef struct packed {
    target_t     target;
    logic [15:0] store_offset;
    logic [7:0]  pass_byte;
  } bsmd_out_t;

  // Configuration register contents.
  typedef struct packed {
    logic enhanced_model;
    logic internal_rom_present;
    logic mouse_card;
    logic disk_card;
    logic hard_disk_card;
  } bsmd_cfg_t;

  // Update request for the internal $C8 ROM flag.
  typedef struct packed {
    logic update;
    logic value;
  } bsmd_c8_t;

  // Opcode values.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Soft-switch flag bit positions.
  localparam int unsigned FLG_ALTZP     = 0;
  localparam int unsigned FLG_80STORE   = 1;
  localparam int unsigned FLG_RAMRD     = 2;
  localparam int unsigned FLG_RAMWRT    = 3;
  localparam int unsigned FLG_PAGE1     = 4;
  localparam int unsigned FLG_LORES     = 5;
  localparam int unsigned FLG_INTCXROM  = 6;
  localparam int unsigned FLG_SLOTC3ROM = 7;
  localparam int unsigned FLG_LCREAD    = 8;
  localparam int unsigned FLG_BANKREAD  = 9;
  localparam int unsigned FLG_BANK2_1   = 10;
  localparam int unsigned FLG_LCWRITE   = 11;

  // Address map.
  localparam logic [15:0] ADDR_ZP_END   = 16'h0200;
  localparam logic [15:0] ADDR_TEXT_LO  = 16'h0400;
  localparam logic [15:0] ADDR_TEXT_HI  = 16'h0800;
  localparam logic [15:0] ADDR_HIRES_LO = 16'h2000;
  localparam logic [15:0] ADDR_HIRES_HI = 16'h4000;
  localparam logic [15:0] ADDR_IO_BASE  = 16'hC000;
  localparam logic [15:0] ADDR_SPEAKER  = 16'hC030;
  localparam logic [15:0] ADDR_SLOT_LO  = 16'hC100;
  localparam logic [15:0] ADDR_SLOT3    = 16'hC300;
  localparam logic [15:0] ADDR_SLOT4    = 16'hC400;
  localparam logic [15:0] ADDR_SLOT5    = 16'hC500;
  localparam logic [15:0] ADDR_SLOT6    = 16'hC600;
  localparam logic [15:0] ADDR_SLOT7    = 16'hC700;
  localparam logic [15:0] ADDR_C8_BASE  = 16'hC800;
  localparam logic [15:0] ADDR_LC_BASE  = 16'hD000;
  localparam logic [15:0] ADDR_B1_BASE  = 16'hE000;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_ENHANCED = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INT_ROM  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MOUSE    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DISK     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HD       = 3'd4;

endpackage

// ===== sv/bsmd_decode.sv =====
// ----------------------------------------------------------------------------
// bsmd_decode
// Combinational address decode: picks the target store and the offset into it
// for one bus access, and requests updates of the internal $C8 ROM flag.
// ----------------------------------------------------------------------------
module bsmd_decode
  import bsmd_pkg::*;
(
  input  bsmd_in_t  item,
  input  bsmd_cfg_t cfg,
  input  logic      c8_rom_en,
  output bsmd_out_t result,
  output bsmd_c8_t  c8_req
);

  logic        wr;
  logic [15:0] a;
  logic [11:0] f;
  logic [7:0]  b;
  logic        alt_sel;
  logic        mixed_page;
  target_t     low_tgt;
  target_t     bank_tgt;
  logic [15:0] bank_off;
  target_t     rom_tgt;
  logic [15:0] rom_off;
  logic [15:0] off_io;
  logic [15:0] off_lc;

  assign wr = (item.opcode == OP_WRITE);
  assign a  = item.bus_address;
  assign f  = item.switch_flags;
  assign b  = wr ? item.write_byte : 8'd0;

  assign off_io = a - ADDR_IO_BASE;
  assign off_lc = a - ADDR_LC_BASE;

  // Main or aux RAM below $C000, with the 80STORE display page override.
  always_comb begin
    alt_sel    = wr ? f[FLG_RAMWRT] : f[FLG_RAMRD];
    mixed_page = f[FLG_80STORE] &&
                 (((a >= ADDR_TEXT_LO) && (a < ADDR_TEXT_HI)) ||
                  ((a >= ADDR_HIRES_LO) && (a < ADDR_HIRES_HI) && !f[FLG_LORES]));
    if (mixed_page) begin
      low_tgt = f[FLG_PAGE1] ? TGT_RAM : TGT_AUXRAM;
    end else begin
      low_tgt = alt_sel ? TGT_AUXRAM : TGT_RAM;
    end
  end

  // Enhanced-model bank RAM at $D000-$FFFF.
  always_comb begin
    if (a < ADDR_B1_BASE) begin
      bank_off = off_lc;
      if (f[FLG_BANK2_1]) begin
        bank_tgt = f[FLG_ALTZP] ? TGT_AUX_B21 : TGT_MAIN_B21;
      end else begin
        bank_tgt = f[FLG_ALTZP] ? TGT_AUX_B22 : TGT_MAIN_B22;
      end
    end else begin
      bank_off = a - ADDR_B1_BASE;
      bank_tgt = f[FLG_ALTZP] ? TGT_AUX_B1 : TGT_MAIN_B1;
    end
  end

  // Internal ROM when its image is loaded, otherwise no store.
  always_comb begin
    if (cfg.internal_rom_present) begin
      rom_tgt = TGT_INTROM;
      rom_off = off_io;
    end else begin
      rom_tgt = TGT_NONE;
      rom_off = 16'd0;
    end
  end

  // Main decode tree.
  always_comb begin
    result.target       = TGT_NONE;
    result.store_offset = 16'd0;
    result.pass_byte    = b;
    c8_req              = '0;

    if (a < ADDR_ZP_END) begin
      result.target       = f[FLG_ALTZP] ? TGT_AUXZP : TGT_ZP;
      result.store_offset = a;
    end else if (a < ADDR_IO_BASE) begin
      result.target       = low_tgt;
      result.store_offset = a;
    end else if (a < ADDR_SLOT_LO) begin
      if (a == ADDR_SPEAKER) begin
        result.target = TGT_SPEAKER;
      end else begin
        result.target       = TGT_SWITCH;
        result.store_offset = off_io;
      end
    end else if (wr) begin
      // Slot-area writes go nowhere; above it, bank RAM or LC (if LCWRITE).
      if (a < ADDR_LC_BASE) begin
        result.target = TGT_NONE;
      end else if (cfg.enhanced_model) begin
        result.target       = bank_tgt;
        result.store_offset = bank_off;
      end else if (f[FLG_LCWRITE]) begin
        result.target       = TGT_LC;
        result.store_offset = off_lc;
      end
    end else if (a >= ADDR_LC_BASE) begin
      // Reads of the language-card area.
      if (f[FLG_LCREAD]) begin
        result.target       = TGT_LC;
        result.store_offset = off_lc;
      end else if (!cfg.enhanced_model) begin
        result.target       = TGT_SYSROM;
        result.store_offset = off_lc;
      end else if (f[FLG_BANKREAD]) begin
        result.target       = bank_tgt;
        result.store_offset = bank_off;
      end else begin
        result.target       = rom_tgt;
        result.store_offset = rom_off;
      end
    end else if ((a < ADDR_C8_BASE) && cfg.internal_rom_present && f[FLG_INTCXROM]) begin
      result.target       = TGT_INTROM;
      result.store_offset = off_io;
    end else if ((a >= ADDR_SLOT3) && (a < ADDR_SLOT4)) begin
      // Slot 3 read also decides whether the $C8 ROM is internal.
      c8_req.update = 1'b1;
      if (cfg.internal_rom_present && !f[FLG_SLOTC3ROM]) begin
        c8_req.value        = 1'b1;
        result.target       = TGT_INTROM;
        result.store_offset = off_io;
      end
    end else if ((a >= ADDR_SLOT4) && (a < ADDR_SLOT5)) begin
      if (cfg.mouse_card) begin
        result.target       = TGT_MOUSE;
        result.store_offset = a - ADDR_SLOT4;
      end
    end else if ((a >= ADDR_SLOT6) && (a < ADDR_SLOT7)) begin
      if (cfg.disk_card) begin
        result.target       = TGT_DISK;
        result.store_offset = a - ADDR_SLOT6;
      end
    end else if ((a >= ADDR_SLOT7) && (a < ADDR_C8_BASE)) begin
      if (cfg.hard_disk_card) begin
        result.target       = TGT_HD;
        result.store_offset = a - ADDR_SLOT7;
      end
    end else if ((a >= ADDR_C8_BASE) && cfg.internal_rom_present && c8_rom_en) begin
      result.target       = TGT_INTROM;
      result.store_offset = off_io;
    end else if (cfg.enhanced_model) begin
      // Unclaimed slot-area read.
      result.target       = rom_tgt;
      result.store_offset = rom_off;
    end
  end

endmodule

// ===== sv/bank_switched_memory_decoder.sv =====
// ----------------------------------------------------------------------------
// bank_switched_memory_decoder
// Routes 6502 bus accesses to main, aux, ROM, card and bank stores.
// ----------------------------------------------------------------------------
// The block takes one bus access per clock while in_ready is high and returns
// one routing result per access, in order: the access is captured in an input
// register, decoded by a single pass of range compares and muxes, and the
// result is held in an output register until it is taken. A stalled output
// holds the input register, so in_ready drops only while both registers are
// full. The only state beyond the pipeline is the internal $C8 ROM flag,
// updated as a slot 3 read moves into the output register. The five one-bit
// configuration registers sit at byte addresses 0, 4, 8, 12 and 16 of the APB
// port and must be written while no item is in flight.
module bank_switched_memory_decoder
  import bsmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bsmd_in_t              in_data,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output bsmd_out_t             out_data,
  // Configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  bsmd_cfg_t            cfg_r;
  bsmd_cfg_t            cfg_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  logic                 s1_valid_r;
  bsmd_in_t             s1_data_r;
  logic                 out_valid_r;
  bsmd_out_t            out_data_r;
  logic                 c8_rom_r;
  logic                 c8_rom_nxt;

  logic                 out_load;
  logic                 s1_load;
  bsmd_out_t            dec_result;
  bsmd_c8_t             c8_req;

  // Configuration register access.
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_ENHANCED: cfg_nxt.enhanced_model       = cfg_pwdata[0];
        REG_INT_ROM:  cfg_nxt.internal_rom_present = cfg_pwdata[0];
        REG_MOUSE:    cfg_nxt.mouse_card           = cfg_pwdata[0];
        REG_DISK:     cfg_nxt.disk_card            = cfg_pwdata[0];
        REG_HD:       cfg_nxt.hard_disk_card       = cfg_pwdata[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      REG_ENHANCED: cfg_prdata[0] = cfg_r.enhanced_model;
      REG_INT_ROM:  cfg_prdata[0] = cfg_r.internal_rom_present;
      REG_MOUSE:    cfg_prdata[0] = cfg_r.mouse_card;
      REG_DISK:     cfg_prdata[0] = cfg_r.disk_card;
      REG_HD:       cfg_prdata[0] = cfg_r.hard_disk_card;
      default:      cfg_prdata = '0;
    endcase
  end

  // Pipeline flow: the output register frees when its item is taken.
  assign out_load  = !out_valid_r || out_ready;
  assign s1_load   = !s1_valid_r || out_load;
  assign in_ready  = s1_load;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bsmd_decode u_decode (
    .item      (s1_data_r),
    .cfg       (cfg_r),
    .c8_rom_en (c8_rom_r),
    .result    (dec_result),
    .c8_req    (c8_req)
  );

  // The flag changes only when the slot 3 read leaves the input register.
  assign c8_rom_nxt = (s1_valid_r && out_load && c8_req.update) ? c8_req.value
                                                                 : c8_rom_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      c8_rom_r    <= 1'b0;
    end else begin
      cfg_r      <= cfg_nxt;
      c8_rom_r   <= c8_rom_nxt;
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_data_r <= in_data;
    end
    if (out_load && s1_valid_r) begin
      out_data_r <= dec_result;
    end
  end

endmodule

// ===== sv/bsmd_checker.sv =====
// ----------------------------------------------------------------------------
// bsmd_checker
// Port-level checks for the bank-switched memory decoder, bound to the top.
// ----------------------------------------------------------------------------
module bsmd_checker
  import bsmd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input bsmd_out_t out_data
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Input back-pressure only comes from a stalled, full output.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the output could move");

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result item changed");

  // Speaker and unrouted accesses carry no offset.
  a_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_data.target == TGT_NONE) || (out_data.target == TGT_SPEAKER)))
    |-> (out_data.store_offset == 16'd0))
    else $error("offset given for a store without one");

endmodule

bind bank_switched_memory_decoder bsmd_checker u_bsmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
